@@ hw/rtl/rcsc_pkg.sv @@
// shared types and constants for the rc stick and mode switch conditioner
`timescale 1ns / 1ps

package rcsc_pkg;

    localparam int STICK_W     = 16;
    localparam int LEVEL_W     = 16;
    localparam int NUM_STICKS  = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DZ_W        = 15;
    localparam int GAIN_FRAC   = 12;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 88;

    localparam logic [STICK_W-1:0] FULL_SCALE   = 16'd32767;
    localparam logic [STICK_W-1:0] CENTER_LIMIT = 16'd1638;
    localparam logic [LEVEL_W-1:0] LEVEL_OFFSET = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZONE_WIDTH      = 3'd0,
        CFG_ZONE_GAIN       = 3'd1,
        CFG_FILTER_WEIGHT   = 3'd2,
        CFG_MODE_THRESHOLD  = 3'd3,
        CFG_MODE_HYSTERESIS = 3'd4,
        CFG_GEAR_THRESHOLD  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]         pad;
        logic               sticks_centered;
        logic               command_entered;
        logic               command_active;
        logic               hover_entered;
        logic               hover_active;
        logic [LEVEL_W-1:0] mode_level;
        logic [STICK_W-1:0] yaw_out;
        logic [STICK_W-1:0] throttle_out;
        logic [STICK_W-1:0] pitch_out;
        logic [STICK_W-1:0] roll_out;
    } result_t;

endpackage

@@ hw/rtl/rc_stick_and_mode_switch_conditioner.sv @@
// rc stick dead zone, aux level filter and hover/command mode switch logic
// path: an input transfer fills the input register, which loads the result register that drives m_tvalid
// throughput: one frame per cycle; a stalled result lets one more frame into the input
// register, then s_tready drops until the result transfer
// reset (aresetn low, synchronous): stages empty, config registers and mode state to defaults
`timescale 1ns / 1ps

module rc_stick_and_mode_switch_conditioner
    import rcsc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // roll_stick, pitch_stick, throttle_stick, yaw_stick, mode_switch_raw, gear_switch_raw
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // roll_out, pitch_out, throttle_out, yaw_out, mode_level, hover_active,
    // hover_entered, command_active, command_entered, sticks_centered, 3 zero bits
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [DZ_W-1:0]    zone_half_reg;
    logic [15:0]        gain_reg;
    logic [15:0]        weight_reg;
    logic [LEVEL_W-1:0] mode_th_reg;
    logic [LEVEL_W-1:0] mode_hyst_reg;
    logic [LEVEL_W-1:0] gear_th_reg;

    logic                  in_valid_reg;
    logic [IN_TDATA_W-1:0] in_data_reg;
    logic                  out_valid_reg;
    result_t               out_data_reg;
    result_t               out_next;

    logic [LEVEL_W-1:0] filt_reg, filt_next;
    logic [LEVEL_W-1:0] prev_mode_reg;
    logic [LEVEL_W-1:0] prev_gear_reg;
    logic               seen_reg;
    logic               hover_reg, hover_next;
    logic               cmd_reg, cmd_next;
    logic               cmd_entry_reg, cmd_entry_next;

    logic out_ready;
    logic advance;

    // dead zone, rescale with round half away from zero, saturate
    function automatic logic [STICK_W-1:0] condition_stick(
        input logic [STICK_W-1:0] s,
        input logic [DZ_W-1:0]    z,
        input logic [15:0]        gain
    );
        logic signed [16:0] ss;
        logic signed [16:0] zs;
        logic signed [16:0] d;
        logic               pos;
        logic               neg;
        logic [15:0]        mag;
        logic [31:0]        rnd;
        logic [19:0]        q;
        logic [STICK_W-1:0] sat;
        ss  = {s[STICK_W-1], s};
        zs  = {2'b00, z};
        pos = ss > zs;
        neg = ss < -zs;
        d   = pos ? (ss - zs) : (ss + zs);
        mag = d[16] ? 16'(-d) : d[15:0];
        rnd = 32'(mag) * 32'(gain) + 32'd2048;
        q   = rnd[31:GAIN_FRAC];
        sat = (q > 20'(FULL_SCALE)) ? FULL_SCALE : q[STICK_W-1:0];
        if (pos) begin
            return sat;
        end else if (neg) begin
            return -sat;
        end else begin
            return '0;
        end
    endfunction

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_half_reg <= '0;
            gain_reg      <= 16'd4096;
            weight_reg    <= '0;
            mode_th_reg   <= 16'd32768;
            mode_hyst_reg <= 16'd3277;
            gear_th_reg   <= 16'd32768;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ZONE_WIDTH:      zone_half_reg <= cfg_wdata[DZ_W-1:0];
                CFG_ZONE_GAIN:       gain_reg      <= cfg_wdata;
                CFG_FILTER_WEIGHT:   weight_reg    <= cfg_wdata;
                CFG_MODE_THRESHOLD:  mode_th_reg   <= cfg_wdata;
                CFG_MODE_HYSTERESIS: mode_hyst_reg <= cfg_wdata;
                CFG_GEAR_THRESHOLD:  gear_th_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [LEVEL_W-1:0]  mode_lvl;
        logic [LEVEL_W-1:0]  gear_lvl;
        logic [LEVEL_W-1:0]  prev_mode;
        logic [LEVEL_W-1:0]  prev_gear;
        logic [31:0]         acc;
        logic signed [17:0]  exit_lvl;
        logic [STICK_W-1:0]  st [NUM_STICKS];
        logic                centered;
        logic                entered;

        centered = 1'b1;
        for (int i = 0; i < NUM_STICKS; i++) begin
            st[i] = condition_stick(in_data_reg[i*STICK_W +: STICK_W], zone_half_reg,
                                    gain_reg);
            if ($signed(st[i]) > $signed(CENTER_LIMIT) ||
                $signed(st[i]) < -$signed(CENTER_LIMIT)) begin
                centered = 1'b0;
            end
        end

        mode_lvl = in_data_reg[4*STICK_W +: STICK_W] + LEVEL_OFFSET;
        gear_lvl = in_data_reg[5*STICK_W +: STICK_W] + LEVEL_OFFSET;

        // sum stays below 2^32 for every weight and level
        acc = 32'(weight_reg) * 32'(filt_reg)
            + (32'h0001_0000 - 32'(weight_reg)) * 32'(mode_lvl)
            + 32'd32768;
        filt_next = acc[31:16];

        // first frame seeds the edge detectors with the raw levels
        prev_mode = seen_reg ? prev_mode_reg : mode_lvl;
        prev_gear = seen_reg ? prev_gear_reg : gear_lvl;

        entered  = (prev_mode < mode_th_reg) && (filt_next > mode_th_reg);
        exit_lvl = $signed({2'b00, mode_th_reg}) - $signed({2'b00, mode_hyst_reg});

        hover_next = hover_reg;
        if (hover_reg) begin
            if ($signed({2'b00, filt_next}) < exit_lvl) begin
                hover_next = 1'b0;
            end
        end else if (filt_next > mode_th_reg) begin
            hover_next = 1'b1;
        end

        cmd_next       = cmd_reg;
        cmd_entry_next = cmd_entry_reg;
        if (hover_next) begin
            priority if (prev_gear < gear_th_reg && gear_lvl > gear_th_reg) begin
                cmd_entry_next = 1'b1;
            end else if (gear_lvl < gear_th_reg) begin
                cmd_entry_next = 1'b0;
            end else begin
                cmd_entry_next = cmd_entry_reg;
            end
            cmd_next = gear_lvl > gear_th_reg;
        end

        out_next.roll_out        = st[0];
        out_next.pitch_out       = st[1];
        out_next.throttle_out    = st[2];
        out_next.yaw_out         = st[3];
        out_next.mode_level      = filt_next;
        out_next.hover_active    = hover_next;
        out_next.hover_entered   = entered;
        out_next.command_active  = cmd_next;
        out_next.command_entered = cmd_entry_next;
        out_next.sticks_centered = centered;
        out_next.pad             = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            filt_reg      <= '0;
            prev_mode_reg <= '0;
            prev_gear_reg <= '0;
            seen_reg      <= 1'b0;
            hover_reg     <= 1'b1;
            cmd_reg       <= 1'b1;
            cmd_entry_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                filt_reg      <= filt_next;
                prev_mode_reg <= filt_next;
                prev_gear_reg <= in_data_reg[5*STICK_W +: STICK_W] + LEVEL_OFFSET;
                seen_reg      <= 1'b1;
                hover_reg     <= hover_next;
                cmd_reg       <= cmd_next;
                cmd_entry_reg <= cmd_entry_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= out_next;
        end
    end

endmodule

@@ hw/rtl/rcsc_checker.sv @@
// port-level assertions for the rc stick and mode switch conditioner
`timescale 1ns / 1ps

module rcsc_port_props
    import rcsc_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    result_t res;
    assign res = m_tdata;

    // a stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a frame that enters hover must report hover held
    a_enter_hover: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.hover_entered |-> res.hover_active)
        else $error("hover entered without hover active");

    a_centered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.sticks_centered |->
            $signed(res.roll_out) <= $signed(CENTER_LIMIT) &&
            $signed(res.roll_out) >= -$signed(CENTER_LIMIT) &&
            $signed(res.pitch_out) <= $signed(CENTER_LIMIT) &&
            $signed(res.pitch_out) >= -$signed(CENTER_LIMIT) &&
            $signed(res.throttle_out) <= $signed(CENTER_LIMIT) &&
            $signed(res.throttle_out) >= -$signed(CENTER_LIMIT) &&
            $signed(res.yaw_out) <= $signed(CENTER_LIMIT) &&
            $signed(res.yaw_out) >= -$signed(CENTER_LIMIT))
        else $error("centered flag with a large stick");

    // saturation is symmetric, so the most negative code never shows
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.pad == 3'b000 &&
            res.roll_out != 16'h8000 && res.pitch_out != 16'h8000 &&
            res.throttle_out != 16'h8000 && res.yaw_out != 16'h8000)
        else $error("stick out of range or pad bits set");

endmodule

bind rc_stick_and_mode_switch_conditioner rcsc_port_props u_rcsc_port_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
